/* hw/rtl/rwr_pkg.sv */
// ----------------------------------------------------------------------------
// rwr_pkg
// Shared types and constants for the record word reverser.
// ----------------------------------------------------------------------------
package rwr_pkg;

  localparam int WORD_W    = 32;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  // register indexes (byte address = 4 * index)
  localparam logic REG_EOR_THRESHOLD  = 1'b0;
  localparam logic REG_REVERSE_ENABLE = 1'b1;

  localparam logic [WORD_W-1:0] EOR_THRESHOLD_RST = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_STORE,     // hold word in the record store
    CMD_REV,       // drain newest first, then separator
    CMD_FWD_WORD,  // drain in arrival order, then the word
    CMD_FLUSH,     // drain in arrival order, last flag on final beat
    CMD_BYPASS     // store full: word goes out with overflow
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

/* hw/rtl/rwr_front.sv */
// ----------------------------------------------------------------------------
// rwr_front
// Accepts input beats, classifies them into commands and keeps a shadow of
// the store fill level so overflow is decided at accept time.
// ----------------------------------------------------------------------------
module rwr_front
  import rwr_pkg::*;
#(
  parameter int MAX_RECORD = 63,
  parameter int CNT_W      = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,        // [31:0] in_word
  input  logic [0:0]        s_tuser,        // [0] mode
  input  logic [WORD_W-1:0] eor_threshold,
  input  logic              reverse_enable,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd.word = s_tdata;
    fill_next  = fill;
    if (s_tuser[0]) begin
      q_cmd.kind = CMD_FLUSH;
      fill_next  = '0;
    end else if (!reverse_enable) begin
      q_cmd.kind = CMD_FWD_WORD;
      fill_next  = '0;
    end else if (s_tdata >= eor_threshold) begin
      q_cmd.kind = CMD_REV;
      fill_next  = '0;
    end else if (fill < CNT_W'(MAX_RECORD)) begin
      q_cmd.kind = CMD_STORE;
      fill_next  = fill + CNT_W'(1);
    end else begin
      q_cmd.kind = CMD_BYPASS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (q_push) begin
      fill <= fill_next;
    end
  end

endmodule

/* hw/rtl/rwr_queue.sv */
// ----------------------------------------------------------------------------
// rwr_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rwr_queue
  import rwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] level;
  logic               do_push;
  logic               do_pop;

  assign full    = (level == Q_CNT_W'(Q_DEPTH));
  assign empty   = (level == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (do_push && !do_pop) begin
        level <= level + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        level <= level - Q_CNT_W'(1);
      end
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= Q_CNT_W'(Q_DEPTH))
    else $error("queue level beyond depth");

endmodule

/* hw/rtl/rwr_back.sv */
// ----------------------------------------------------------------------------
// rwr_back
// Executes commands: holds record words in the store and drains them to the
// output register one beat per cycle unless stalled, newest or oldest first.
// ----------------------------------------------------------------------------
module rwr_back
  import rwr_pkg::*;
#(
  parameter int MAX_RECORD = 63,
  parameter int CNT_W      = 6,
  parameter int IDX_W      = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] out_word
  output logic        m_tlast,
  output logic [0:0]  m_tuser    // [0] overflow
);

  typedef enum logic [1:0] {ST_IDLE, ST_DRAIN, ST_TAIL} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  cmd_t              cur;
  logic [WORD_W-1:0] mem [MAX_RECORD];

  logic              out_free;
  logic              out_load;
  logic              drain_last;
  logic [IDX_W-1:0]  last_idx;

  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = out_free && (state == ST_DRAIN || state == ST_TAIL);
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign last_idx   = IDX_W'(count - CNT_W'(1));
  assign drain_last = (cur.kind == CMD_REV) ? (idx == '0) : (idx == last_idx);

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == CMD_STORE) begin
      mem[count[IDX_W-1:0]] <= q_head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur <= q_head;
            unique case (q_head.kind)
              CMD_STORE: begin
                count <= count + CNT_W'(1);
              end
              CMD_FLUSH: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= ST_DRAIN;
                end
              end
              CMD_REV: begin
                if (count != '0) begin
                  idx   <= IDX_W'(count - CNT_W'(1));
                  state <= ST_DRAIN;
                end else begin
                  state <= ST_TAIL;
                end
              end
              CMD_FWD_WORD: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= ST_DRAIN;
                end else begin
                  state <= ST_TAIL;
                end
              end
              CMD_BYPASS: begin
                state <= ST_TAIL;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= mem[idx];
            m_tlast    <= (cur.kind == CMD_FLUSH) && drain_last;
            m_tuser[0] <= 1'b0;
            if (drain_last) begin
              count <= '0;
              state <= (cur.kind == CMD_FLUSH) ? ST_IDLE : ST_TAIL;
            end else if (cur.kind == CMD_REV) begin
              idx <= idx - IDX_W'(1);
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_TAIL: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= cur.word;
            m_tlast    <= 1'b1;
            m_tuser[0] <= (cur.kind == CMD_BYPASS);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_ovf_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("overflow beat without last");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> count != '0)
    else $error("draining an empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RECORD))
    else $error("store count beyond capacity");

endmodule

/* hw/rtl/record_word_reverser_core.sv */
// ----------------------------------------------------------------------------
// record_word_reverser_core
// Cuts a word ID stream into records and reverses the words of each record.
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tuser[0] is the mode (1 = flush), s_tdata the
// word. Results leave on m_*: m_tdata is the word, m_tlast marks the final
// result of an input beat, m_tuser[0] flags a word that bypassed a full store.
// Registers sit on the APB port: eor_threshold at 0x0, reverse_enable at 0x4;
// write them only while the block is idle.
// A front stage classifies each beat into a command and pushes it into a
// two-entry queue; the back stage runs commands against the record store.
// An input beat is taken whenever the queue has room. A stored word is
// absorbed by the back stage without leaving its idle state. A drain of n
// held words gives one result per cycle while m_tready is high; the back
// stage pops the command, drains the words, then sends the separator from
// its tail state. Input stalls once the queue fills. The output register
// holds its beat while m_tready is low and the back stage waits for it.
// Reset empties the queue and the store count and drops m_tvalid; store
// contents stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
module record_word_reverser_core
  import rwr_pkg::*;
#(
  parameter int MAX_RECORD = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] in_word
  input  logic [0:0]  s_tuser,    // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] out_word
  output logic        m_tlast,
  output logic [0:0]  m_tuser,    // [0] overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_RECORD + 1);
  localparam int IDX_W = (MAX_RECORD > 1) ? $clog2(MAX_RECORD) : 1;

  logic [WORD_W-1:0] eor_threshold;
  logic              reverse_enable;
  logic              reg_wr;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_REVERSE_ENABLE) ? {31'b0, reverse_enable}
                                                   : eor_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      eor_threshold  <= EOR_THRESHOLD_RST;
      reverse_enable <= 1'b1;
    end else if (reg_wr) begin
      if (paddr[2] == REG_EOR_THRESHOLD) begin
        eor_threshold <= pwdata;
      end else begin
        reverse_enable <= pwdata[0];
      end
    end
  end

  rwr_front #(
    .MAX_RECORD (MAX_RECORD),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .eor_threshold  (eor_threshold),
    .reverse_enable (reverse_enable),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  rwr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rwr_back #(
    .MAX_RECORD (MAX_RECORD),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for record_word_reverser_core.
// Word and flush beats go in on the s_* stream. Each accepted beat is run
// through a local model of the record store, and the results it predicts
// queue up. Every beat that leaves on m_* is compared field by field with the
// oldest queued result. Registers change over APB only while the block is
// idle. The bench covers directed corner cases, a full store, a long
// receiver hold-off, and random record streams under several settings.
// ----------------------------------------------------------------------------
module tb_top
  import rwr_pkg::*;
();

  localparam int STORE_DEPTH = 63;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES = 200;
  localparam int unsigned LIMIT_NS = 20_000_000;

  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        ovf;
  } result_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] in_word
  logic [0:0]  s_tuser = '0;   // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] out_word
  logic        m_tlast;
  logic [0:0]  m_tuser;        // [0] overflow
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shared bench control, updated with nonblocking assignments at the edge
  logic idle_on = 1'b0;
  logic sink_held = 1'b0;
  int   sink_gap = 0;

  int unsigned err_cnt = 0;
  int unsigned beats_in = 0;

  // local copy of the block's state and registers
  logic [31:0]  held_words [STORE_DEPTH];
  int           held_cnt = 0;
  logic [31:0]  cur_thr = EOR_THRESHOLD_RST;
  logic         cur_rev = 1'b1;
  result_beat_t pending_results [$];

  record_word_reverser_core #(
    .MAX_RECORD(STORE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic void queue_result(input logic [31:0] word, input logic last,
                                       input logic ovf);
    result_beat_t r;
    r.word = word;
    r.last = last;
    r.ovf  = ovf;
    pending_results.push_back(r);
  endfunction

  // results of one accepted beat against the held record
  function automatic void reverse_records(input logic flush, input logic [31:0] word);
    int i;
    if (flush) begin
      for (i = 0; i < held_cnt; i++)
        queue_result(held_words[i], i == held_cnt - 1, 1'b0);
      held_cnt = 0;
    end else if (!cur_rev) begin
      for (i = 0; i < held_cnt; i++)
        queue_result(held_words[i], 1'b0, 1'b0);
      held_cnt = 0;
      queue_result(word, 1'b1, 1'b0);
    end else if (word >= cur_thr) begin
      for (i = held_cnt - 1; i >= 0; i--)
        queue_result(held_words[i], 1'b0, 1'b0);
      held_cnt = 0;
      queue_result(word, 1'b1, 1'b0);
    end else if (held_cnt < STORE_DEPTH) begin
      held_words[held_cnt] = word;
      held_cnt++;
    end else begin
      queue_result(word, 1'b1, 1'b1);
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    result_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", m_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.word) report_mismatch("out_word", m_tdata, want.word);
        if (m_tlast !== want.last)
          report_mismatch("run_last", {31'b0, m_tlast}, {31'b0, want.last});
        if (m_tuser[0] !== want.ovf)
          report_mismatch("overflow", {31'b0, m_tuser[0]}, {31'b0, want.ovf});
      end
    end
  end

  // receiver: random stall bursts, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_held) begin
      m_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one input beat; valid stays high afterwards unless a gap or a drain follows
  task automatic send_beat(input logic flush, input logic [31:0] word);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= flush;
    do @(posedge clk); while (!s_tready);
    reverse_records(flush, word);
    beats_in++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // stored words make no result but may still sit in the command queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_EOR_THRESHOLD) cur_thr = val;
    else cur_rev = val[0];
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_EOR_THRESHOLD) begin
      if (prdata !== val) report_mismatch("eor_threshold readback", prdata, val);
    end else begin
      if (prdata[0] !== val[0])
        report_mismatch("reverse_enable readback", {31'b0, prdata[0]}, {31'b0, val[0]});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [31:0] thr, input logic rev);
    wait_drained();
    write_reg(REG_EOR_THRESHOLD, thr);
    write_reg(REG_REVERSE_ENABLE, {31'b0, rev});
  endtask

  // a word that is held under threshold thr (thr must be nonzero)
  function automatic logic [31:0] pick_word(input logic [31:0] thr);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return thr - 1;
    return $urandom % thr;
  endfunction

  function automatic logic [31:0] pick_sep(input logic [31:0] thr);
    logic [63:0] span;
    int r;
    span = 64'h1_0000_0000 - {32'b0, thr};
    r = $urandom_range(0, 9);
    if (r == 0) return thr;
    if (r == 1) return 32'hFFFF_FFFF;
    return thr + 32'(({32'b0, $urandom}) % span);
  endfunction

  function automatic int record_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 97) return $urandom_range(13, 40);
    return $urandom_range(60, 66);
  endfunction

  task automatic test_directed();
    idle_on <= 1'b1;
    // reset settings: only all-ones ends a record
    send_beat(1'b0, 32'h0000_0000);
    send_beat(1'b0, 32'hFFFF_FFFE);
    send_beat(1'b0, 32'h5555_5555);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'hFFFF_FFFF);   // separator on an empty record
    send_beat(1'b1, 32'hDEAD_BEEF);   // flush with nothing held
    send_beat(1'b0, 32'hAAAA_AAAA);
    send_beat(1'b0, 32'h1234_5678);
    send_beat(1'b1, 32'h0000_0000);   // flush keeps arrival order
    send_beat(1'b0, 32'h8000_0001);
    send_beat(1'b1, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_config_edges();
    set_mode(32'h8000_0000, 1'b1);
    send_beat(1'b0, 32'h7FFF_FFFF);
    send_beat(1'b0, 32'h0000_0001);
    send_beat(1'b0, 32'h8000_0000);   // equal to threshold ends the record
    send_beat(1'b0, 32'hFFFF_FFFF);
    set_mode(32'h0000_0000, 1'b1);    // every word is a separator
    send_beat(1'b0, 32'h0000_0000);
    send_beat(1'b0, 32'h0000_0007);
    set_mode(32'h0000_0001, 1'b1);
    send_beat(1'b0, 32'h0000_0000);
    send_beat(1'b0, 32'h0000_0000);
    send_beat(1'b0, 32'h0000_0001);
    send_beat(1'b0, 32'hFFFF_FFFF);
    // reversal switched off with words still held
    set_mode(32'hFFFF_FFFF, 1'b1);
    send_beat(1'b0, 32'h0000_0011);
    send_beat(1'b0, 32'h0000_0022);
    send_beat(1'b0, 32'h0000_0033);
    set_mode(32'hFFFF_FFFF, 1'b0);
    send_beat(1'b0, 32'h0000_0044);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'h0000_0000);
    set_mode(32'hFFFF_FFFF, 1'b1);
    send_beat(1'b0, 32'h0000_0055);
    send_beat(1'b0, 32'h0000_0066);
    set_mode(32'hFFFF_FFFF, 1'b0);
    send_beat(1'b1, 32'h0000_0077);
  endtask

  task automatic test_store_full();
    int i;
    set_mode(32'hFFFF_FFFF, 1'b1);
    idle_on <= 1'b1;
    for (i = 0; i < STORE_DEPTH; i++) send_beat(1'b0, pick_word(cur_thr));
    send_beat(1'b0, 32'hFFFF_FFFE);   // full store: bypass with overflow
    send_beat(1'b0, pick_word(cur_thr));
    send_beat(1'b0, 32'hFFFF_FFFF);
    for (i = 0; i < STORE_DEPTH; i++) send_beat(1'b0, pick_word(cur_thr));
    send_beat(1'b0, pick_word(cur_thr));
    send_beat(1'b1, $urandom);
  endtask

  task automatic test_backpressure();
    int k;
    int i;
    int len;
    set_mode(32'hFFFF_FFFF, 1'b1);
    idle_on <= 1'b0;
    fork
      begin
        sink_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_held <= 1'b0;
      end
    join_none
    for (k = 0; k < 16; k++) begin
      len = $urandom_range(0, 3);
      for (i = 0; i < len; i++) send_beat(1'b0, pick_word(cur_thr));
      send_beat(1'b0, 32'hFFFF_FFFF);
    end
  endtask

  task automatic random_phase(input logic [31:0] thr, input logic rev, input int n,
                              input logic idling);
    int unsigned start;
    int r;
    int i;
    int len;
    set_mode(thr, rev);
    start = beats_in;
    while (beats_in - start < n) begin
      idle_on <= idling && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_beat(1'b0, $urandom);    // noise
      end else begin
        len = (thr == 0) ? 0 : record_len();
        for (i = 0; i < len; i++) send_beat(1'b0, pick_word(thr));
        if (r < 18) send_beat(1'b1, $urandom);
        else send_beat(1'b0, pick_sep(thr));
      end
    end
  endtask

  task automatic test_random();
    random_phase(32'hFFFF_FFFF, 1'b1, 8, 1'b1);
    random_phase(32'h8000_0000, 1'b1, 8, 1'b1);
    random_phase(32'h0000_1000, 1'b1, 6, 1'b1);
    random_phase($urandom | 32'h1, 1'b1, 6, 1'b1);
    random_phase(32'h0000_0000, 1'b1, 4, 1'b1);
    random_phase(32'h8000_0000, 1'b0, 8, 1'b1);
    // closing stretch runs without idling on either side
    random_phase(32'hC000_0000, 1'b1, 10, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_edges();
    test_store_full();
    test_backpressure();
    test_random();
    wait_drained();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
